### src/bffa_pkg.sv
// Shared constants, types and state codes for the bitmap first-fit allocator.
`default_nettype none
package bffa_pkg;

    // Pool size in bytes, one occupancy bit per byte
    localparam int POOL_BYTES = 128;
    // Field widths of the request and result words
    localparam int LEN_W      = 8;
    localparam int ADDR_OUT_W = 7;
    // Map position counter and run counter widths
    localparam int MAP_AW     = (POOL_BYTES > 1) ? $clog2(POOL_BYTES) : 1;
    localparam int CNT_W      = ($clog2(POOL_BYTES + 1) > LEN_W) ?
                                $clog2(POOL_BYTES + 1) : LEN_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_DONE
    } t_state;

    // Controls from the scanner to the rotating map
    typedef struct packed {
        logic shift;
        logic mark;
    } t_map_ctl;

    // One result word
    typedef struct packed {
        logic                  granted;
        logic [ADDR_OUT_W-1:0] start_address;
    } t_result;

endpackage
`default_nettype wire

### src/bffa_map.sv
// Occupancy map held as a rotating shift register, one bit per pool byte.
`default_nettype none
module bffa_map (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bffa_pkg::t_map_ctl i_ctl,
    output logic                    o_head
);
    import bffa_pkg::*;

    logic [POOL_BYTES-1:0] r_map;
    logic [POOL_BYTES-1:0] n_map;

    // Bit 0 is the byte under the scan position; it re-enters at the top
    always_comb begin
        n_map = r_map;
        if (i_ctl.shift) begin
            n_map = {r_map[0] | i_ctl.mark, r_map[POOL_BYTES-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
        end else begin
            r_map <= n_map;
        end
    end

    assign o_head = r_map[0];

    // Bytes are never released: a step never lowers the used count
    a_no_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> $countones(r_map) >= $countones($past(r_map)))
        else $error("occupancy map lost a used byte");

    // Marks only happen while rotating
    a_mark_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.mark |-> i_ctl.shift)
        else $error("mark without shift");

    // A step without shift leaves the map alone
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.shift |=> r_map == $past(r_map))
        else $error("map changed while idle");

endmodule
`default_nettype wire

### src/bffa_scan.sv
// Bit-serial first-fit search and marking sequencer over the rotating map.
`default_nettype none
module bffa_scan (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_req_valid,
    input  wire logic [bffa_pkg::LEN_W-1:0]  i_req_length,
    output logic                             o_req_ready,
    input  wire logic                        i_head,
    output bffa_pkg::t_map_ctl               o_map_ctl,
    output logic                             o_res_valid,
    output bffa_pkg::t_result                o_res,
    input  wire logic                        i_res_take
);
    import bffa_pkg::*;

    t_state              r_state, n_state;
    logic [MAP_AW-1:0]   r_addr,  n_addr;
    logic [CNT_W-1:0]    r_run,   n_run;
    logic [LEN_W-1:0]    r_want,  n_want;
    logic                r_found, n_found;
    logic [MAP_AW-1:0]   r_start, n_start;
    logic [MAP_AW-1:0]   r_end,   n_end;

    logic                last_pos;
    logic [CNT_W-1:0]    run_inc;
    logic [CNT_W-1:0]    want_ext;
    logic [CNT_W-1:0]    start_calc;
    logic [MAP_AW+ADDR_OUT_W-1:0] start_wide;

    assign last_pos   = (r_addr == MAP_AW'(POOL_BYTES - 1));
    assign run_inc    = r_run + 1'b1;
    assign want_ext   = CNT_W'(r_want);
    assign start_calc = CNT_W'(r_addr) + CNT_W'(1) - want_ext;
    assign start_wide = (MAP_AW + ADDR_OUT_W)'(r_start);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_found <= n_found;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_run   <= n_run;
        r_want  <= n_want;
        r_start <= n_start;
        r_end   <= n_end;
    end

    // Next state and outputs
    always_comb begin
        n_state         = r_state;
        n_addr          = r_addr;
        n_run           = r_run;
        n_want          = r_want;
        n_found         = r_found;
        n_start         = r_start;
        n_end           = r_end;
        o_req_ready     = 1'b0;
        o_map_ctl.shift = 1'b0;
        o_map_ctl.mark  = 1'b0;
        o_res_valid     = 1'b0;
        o_res.granted   = r_found;
        o_res.start_address = r_found ? start_wide[ADDR_OUT_W-1:0] : '0;

        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_want  = i_req_length;
                    n_run   = '0;
                    n_addr  = '0;
                    n_found = 1'b0;
                    n_state = (i_req_length == '0) ? S_DONE : S_SCAN;
                end
            end
            // One map bit per cycle; keep rotating to realign after a hit
            S_SCAN: begin
                o_map_ctl.shift = 1'b1;
                if (!r_found) begin
                    if (!i_head) begin
                        n_run = run_inc;
                        if (run_inc == want_ext) begin
                            n_found = 1'b1;
                            n_end   = r_addr;
                            n_start = MAP_AW'(start_calc);
                        end
                    end else begin
                        n_run = '0;
                    end
                end
                n_addr = MAP_AW'(r_addr + 1'b1);
                if (last_pos) begin
                    n_addr  = '0;
                    n_state = n_found ? S_MARK : S_DONE;
                end
            end
            // Second rotation sets the bits of the granted run
            S_MARK: begin
                o_map_ctl.shift = 1'b1;
                o_map_ctl.mark  = (r_addr >= r_start) && (r_addr <= r_end);
                n_addr = MAP_AW'(r_addr + 1'b1);
                if (last_pos) begin
                    n_addr  = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_idle_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_addr == '0))
        else $error("scan position not at zero when idle");

    a_mark_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |-> r_found)
        else $error("marking without a found run");

    a_run_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |-> (r_start <= r_end))
        else $error("run start past run end");

    a_zero_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_req_valid && i_req_length == '0) |=>
        (r_state == S_DONE && !r_found))
        else $error("zero length request not failed at once");

endmodule
`default_nettype wire

### src/bitmap_first_fit_allocator_top.sv
// o_valid rises from the output word register after the scanner reaches S_DONE,
// which follows acceptance directly for a zero length request, after the scan
// pass on a miss and after the scan and mark passes on a grant; one rotation of
// the serial map per pass. The output register lets the next request in while
// a result waits.
// Reset (synchronous, active low) clears the whole map at once: all bytes free.
`default_nettype none
module bitmap_first_fit_allocator_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [bffa_pkg::LEN_W-1:0]  i_request_length,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic                             o_granted,
    output logic [bffa_pkg::ADDR_OUT_W-1:0]  o_start_address
);
    import bffa_pkg::*;

    t_map_ctl map_ctl;
    t_result  res;
    logic     head;
    logic     req_ready;
    logic     res_valid;
    logic     res_take;

    logic     r_out_valid, n_out_valid;
    t_result  r_out, n_out;

    bffa_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (map_ctl),
        .o_head  (head)
    );

    bffa_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_length (i_request_length),
        .o_req_ready  (req_ready),
        .i_head       (head),
        .o_map_ctl    (map_ctl),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_take   (res_take)
    );

    assign o_stall  = !req_ready;
    assign res_take = res_valid && (!r_out_valid || !i_stall);

    // Output word register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        if (res_take) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid         = r_out_valid;
    assign o_granted       = r_out.granted;
    assign o_start_address = r_out.start_address;

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.granted) |-> (r_out.start_address == '0))
        else $error("failed word carries an address");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !res_take)
        else $error("result word overwritten while stalled");

    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(req_ready && res_valid))
        else $error("scanner idle and holding a result together");

endmodule
`default_nettype wire
